FILE: src/i2c_rts_pkg.sv
// Types, codes and constants shared by the I2C register transaction sequencer.
// Depends on nothing; imported by i2c_register_transaction_sequencer.
package i2c_rts_pkg;

   localparam int unsigned WRITE_BUFFER_BYTES = 32;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd20;
   localparam logic [5:0] WRITE_MAX_LENGTH_RESET = 6'd32;
   localparam logic [15:0] WRITE_BUFFER_LIMIT = 16'(WRITE_BUFFER_BYTES);
   localparam logic [15:0] TICKS_MAX = 16'hFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMEOUT_TICKS    = 2'd0,
      CSR_WRITE_MAX_LENGTH = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      FUNC_BEGIN     = 3'd0,
      FUNC_STATUS    = 3'd1,
      FUNC_BUS_ERROR = 3'd2,
      FUNC_TX_DMA    = 3'd3,
      FUNC_RX_DMA    = 3'd4,
      FUNC_TICK      = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_START      = 3'd1,
      CMD_SEND_BYTE  = 3'd2,
      CMD_TX_DMA     = 3'd3,
      CMD_RX_DMA     = 3'd4,
      CMD_NACK_STOP  = 3'd5,
      CMD_STOP       = 3'd6,
      CMD_STOP_RESET = 3'd7
   } command_type;

   typedef enum logic [1:0] {
      BEGIN_ACCEPTED = 2'd0,
      BEGIN_BUSY     = 2'd1,
      BEGIN_REJECTED = 2'd2
   } begin_status_type;

   typedef enum logic [1:0] {
      DONE_SUCCESS = 2'd0,
      DONE_ERROR   = 2'd1,
      DONE_TIMEOUT = 2'd2
   } done_status_type;

   typedef enum logic [9:0] {
      PH_IDLE        = 10'b00_0000_0001,
      PH_START_W     = 10'b00_0000_0010,
      PH_ADDR_W      = 10'b00_0000_0100,
      PH_REG_SENT    = 10'b00_0000_1000,
      PH_TX_DMA      = 10'b00_0001_0000,
      PH_TX_WAIT_BTF = 10'b00_0010_0000,
      PH_START_R     = 10'b00_0100_0000,
      PH_ADDR_R      = 10'b00_1000_0000,
      PH_RX_ONE      = 10'b01_0000_0000,
      PH_RX_DMA      = 10'b10_0000_0000
   } phase_type;

   localparam int unsigned SF_START_SENT = 0;
   localparam int unsigned SF_ADDR_ACKED = 1;
   localparam int unsigned SF_BYTE_DONE  = 2;
   localparam int unsigned SF_RX_READY   = 3;

   typedef struct packed {
      logic [2:0]  func;
      logic [6:0]  device_address;
      logic [7:0]  register_address;
      logic [15:0] transfer_length;
      logic        read_not_write;
      logic        bus_busy;
      logic [3:0]  status_flags;
      logic [3:0]  error_flags;
      logic        dma_fault;
      logic        dma_complete;
      logic [7:0]  received_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  bus_byte;
      logic [15:0] dma_length;
      logic [1:0]  begin_status;
      logic        done_res;
      logic [1:0]  done_status;
      logic [7:0]  read_byte;
      logic        read_valid;
      logic        transaction_busy;
   } rsp_type;

endpackage

FILE: src/i2c_register_transaction_sequencer.sv
// I2C master register write/read sequencer: one event in, one result item out.
// Depends on i2c_rts_pkg for payload types, codes and reset constants.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall| req_type event
//   rsp     | out       | rsp_valid/rsp_stall| rsp_type result
//   csr     | in        | csr_valid/csr_ready| csr_index, csr_data
//
// One item per cycle while req_stall is low; each event is decoded against the
// phase register in one pass and its result is registered in the cycle after
// acceptance. The single output register is the only buffer: req_stall rises
// only while a result is held and rsp_stall is high. Synchronous reset returns
// the phase to idle and the CSRs to reset values; csr_ready is always high.
module i2c_register_transaction_sequencer
   import i2c_rts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [15:0] timeout_ticks_ff;
   logic [5:0]  write_max_length_ff;
   phase_type   phase_ff, phase_in;
   logic [6:0]  target_address_ff, target_address_in;
   logic [7:0]  target_register_ff, target_register_in;
   logic [15:0] pending_length_ff, pending_length_in;
   logic        is_read_ff, is_read_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_take;
   logic        active;
   logic [15:0] write_limit;
   logic [15:0] elapsed_next;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign active    = (phase_ff != PH_IDLE);
   assign rsp_valid_in = req_take | (rsp_valid_ff & rsp_stall);

   assign write_limit = (16'(write_max_length_ff) > WRITE_BUFFER_LIMIT) ?
                        WRITE_BUFFER_LIMIT : 16'(write_max_length_ff);
   assign elapsed_next = (elapsed_ff < TICKS_MAX) ? elapsed_ff + 16'd1 : elapsed_ff;

   always_comb begin
      phase_in           = phase_ff;
      target_address_in  = target_address_ff;
      target_register_in = target_register_ff;
      pending_length_in  = pending_length_ff;
      is_read_in         = is_read_ff;
      elapsed_in         = elapsed_ff;
      rsp_data_in        = '0;
      unique case (req_data.func)
         FUNC_BEGIN: begin
            if (req_data.transfer_length == 16'd0) begin
               rsp_data_in.begin_status = BEGIN_REJECTED;
            end else if (!req_data.read_not_write &&
                         req_data.transfer_length > write_limit) begin
               rsp_data_in.begin_status = BEGIN_REJECTED;
            end else if (active) begin
               rsp_data_in.begin_status = BEGIN_BUSY;
            end else if (req_data.bus_busy) begin
               rsp_data_in.begin_status = BEGIN_REJECTED;
            end else begin
               target_address_in        = req_data.device_address;
               target_register_in       = req_data.register_address;
               pending_length_in        = req_data.transfer_length;
               is_read_in               = req_data.read_not_write;
               elapsed_in               = 16'd0;
               phase_in                 = PH_START_W;
               rsp_data_in.command      = CMD_START;
               rsp_data_in.begin_status = BEGIN_ACCEPTED;
            end
         end
         FUNC_STATUS: begin
            if (phase_ff == PH_START_W && req_data.status_flags[SF_START_SENT]) begin
               rsp_data_in.command  = CMD_SEND_BYTE;
               rsp_data_in.bus_byte = {target_address_ff, 1'b0};
               phase_in             = PH_ADDR_W;
            end else if (phase_ff == PH_ADDR_W &&
                         req_data.status_flags[SF_ADDR_ACKED]) begin
               rsp_data_in.command  = CMD_SEND_BYTE;
               rsp_data_in.bus_byte = target_register_ff;
               phase_in             = PH_REG_SENT;
            end else if (phase_ff == PH_REG_SENT &&
                         req_data.status_flags[SF_BYTE_DONE]) begin
               if (is_read_ff) begin
                  rsp_data_in.command = CMD_START;
                  phase_in            = PH_START_R;
               end else begin
                  rsp_data_in.command    = CMD_TX_DMA;
                  rsp_data_in.dma_length = pending_length_ff;
                  phase_in               = PH_TX_DMA;
               end
            end else if (phase_ff == PH_START_R &&
                         req_data.status_flags[SF_START_SENT]) begin
               rsp_data_in.command  = CMD_SEND_BYTE;
               rsp_data_in.bus_byte = {target_address_ff, 1'b1};
               phase_in             = PH_ADDR_R;
            end else if (phase_ff == PH_ADDR_R &&
                         req_data.status_flags[SF_ADDR_ACKED]) begin
               if (pending_length_ff == 16'd1) begin
                  rsp_data_in.command = CMD_NACK_STOP;
                  phase_in            = PH_RX_ONE;
               end else begin
                  rsp_data_in.command    = CMD_RX_DMA;
                  rsp_data_in.dma_length = pending_length_ff;
                  phase_in               = PH_RX_DMA;
               end
            end else if (phase_ff == PH_RX_ONE &&
                         req_data.status_flags[SF_RX_READY]) begin
               rsp_data_in.read_byte   = req_data.received_byte;
               rsp_data_in.read_valid  = 1'b1;
               rsp_data_in.command     = CMD_NONE;
               rsp_data_in.done_res    = 1'b1;
               rsp_data_in.done_status = DONE_SUCCESS;
               phase_in                = PH_IDLE;
            end else if (phase_ff == PH_TX_WAIT_BTF &&
                         req_data.status_flags[SF_BYTE_DONE]) begin
               rsp_data_in.command     = CMD_STOP;
               rsp_data_in.done_res    = 1'b1;
               rsp_data_in.done_status = DONE_SUCCESS;
               phase_in                = PH_IDLE;
            end
         end
         FUNC_BUS_ERROR: begin
            if (active && req_data.error_flags != 4'd0) begin
               rsp_data_in.command     = CMD_STOP_RESET;
               rsp_data_in.done_res    = 1'b1;
               rsp_data_in.done_status = DONE_ERROR;
               phase_in                = PH_IDLE;
            end
         end
         FUNC_TX_DMA: begin
            if (active && req_data.dma_fault) begin
               rsp_data_in.command     = CMD_STOP_RESET;
               rsp_data_in.done_res    = 1'b1;
               rsp_data_in.done_status = DONE_ERROR;
               phase_in                = PH_IDLE;
            end else if (phase_ff == PH_TX_DMA && req_data.dma_complete) begin
               phase_in = PH_TX_WAIT_BTF;
            end
         end
         FUNC_RX_DMA: begin
            if (active && req_data.dma_fault) begin
               rsp_data_in.command     = CMD_STOP_RESET;
               rsp_data_in.done_res    = 1'b1;
               rsp_data_in.done_status = DONE_ERROR;
               phase_in                = PH_IDLE;
            end else if (phase_ff == PH_RX_DMA && req_data.dma_complete) begin
               rsp_data_in.command     = CMD_STOP;
               rsp_data_in.done_res    = 1'b1;
               rsp_data_in.done_status = DONE_SUCCESS;
               phase_in                = PH_IDLE;
            end
         end
         FUNC_TICK: begin
            if (active) begin
               elapsed_in = elapsed_next;
               if (elapsed_next > timeout_ticks_ff) begin
                  rsp_data_in.command     = CMD_STOP_RESET;
                  rsp_data_in.done_res    = 1'b1;
                  rsp_data_in.done_status = DONE_TIMEOUT;
                  phase_in                = PH_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.transaction_busy = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff    <= TIMEOUT_TICKS_RESET;
         write_max_length_ff <= WRITE_MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMEOUT_TICKS:    timeout_ticks_ff    <= csr_data[15:0];
            CSR_WRITE_MAX_LENGTH: write_max_length_ff <= csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         target_address_ff  <= target_address_in;
         target_register_ff <= target_register_in;
         pending_length_ff  <= pending_length_in;
         is_read_ff         <= is_read_in;
         elapsed_ff         <= elapsed_in;
         rsp_data_ff        <= rsp_data_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (!rsp_data_ff.done_res || phase_ff == PH_IDLE))
      else $error("done reported while a transaction stays active");

   a_busy_tracks_phase: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (rsp_data_ff.transaction_busy == (phase_ff != PH_IDLE)))
      else $error("transaction_busy disagrees with the phase");

   a_no_accept_when_active: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.func == FUNC_BEGIN && phase_ff != PH_IDLE)
      |=> (rsp_data_ff.begin_status != BEGIN_ACCEPTED))
      else $error("begin accepted during an active transaction");

   a_read_ends_txn: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.read_valid) |-> rsp_data_ff.done_res)
      else $error("read byte delivered without ending the transaction");
`endif

endmodule

FILE: verif/i2c_register_transaction_sequencer_test.sv
// Self-checking testbench for the I2C register transaction sequencer: directed sequences,
// limit and timeout cases, then random event traffic under several register settings.
// Depends on i2c_rts_pkg and i2c_register_transaction_sequencer.
module i2c_register_transaction_sequencer_test;
   import i2c_rts_pkg::*;

   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   localparam logic [3:0] ST_START     = 4'(1 << SF_START_SENT);
   localparam logic [3:0] ST_ACKED     = 4'(1 << SF_ADDR_ACKED);
   localparam logic [3:0] ST_BYTE_DONE = 4'(1 << SF_BYTE_DONE);
   localparam logic [3:0] ST_RX_READY  = 4'(1 << SF_RX_READY);
   localparam logic [3:0] DMA_DONE     = 4'b0001;
   localparam logic [3:0] DMA_FAULT    = 4'b0010;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_TIMEOUT_TICKS;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   i2c_register_transaction_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // sequencer state as predicted
   phase_type   seq_phase = PH_IDLE;
   logic [6:0]  seq_address = '0;
   logic [7:0]  seq_register = '0;
   logic [15:0] seq_length = '0;
   logic        seq_read = 1'b0;
   logic [15:0] seq_ticks = '0;
   logic [15:0] timeout_limit = TIMEOUT_TICKS_RESET;
   logic [5:0]  write_limit = WRITE_MAX_LENGTH_RESET;

   rsp_type     expected_rsp[$];
   logic        gaps_on = 1'b1;
   int unsigned errors = 0;
   int unsigned events_sent = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used = 1;

   function automatic void close_transaction(inout rsp_type r, input command_type cmd,
                                             input done_status_type st);
      r.command     = cmd;
      r.done_res    = 1'b1;
      r.done_status = st;
      seq_phase     = PH_IDLE;
   endfunction

   function automatic rsp_type step_sequencer(req_type ev);
      rsp_type     r;
      logic        active;
      logic [15:0] cap;
      r = '0;
      active = (seq_phase != PH_IDLE);
      cap = (16'(write_limit) > WRITE_BUFFER_LIMIT) ? WRITE_BUFFER_LIMIT : 16'(write_limit);
      case (ev.func)
         FUNC_BEGIN: begin
            if (ev.transfer_length == '0) r.begin_status = BEGIN_REJECTED;
            else if (!ev.read_not_write && ev.transfer_length > cap)
               r.begin_status = BEGIN_REJECTED;
            else if (active) r.begin_status = BEGIN_BUSY;
            else if (ev.bus_busy) r.begin_status = BEGIN_REJECTED;
            else begin
               seq_address  = ev.device_address;
               seq_register = ev.register_address;
               seq_length   = ev.transfer_length;
               seq_read     = ev.read_not_write;
               seq_ticks    = '0;
               seq_phase    = PH_START_W;
               r.command      = CMD_START;
               r.begin_status = BEGIN_ACCEPTED;
            end
         end
         FUNC_STATUS: begin
            if (seq_phase == PH_START_W && ev.status_flags[SF_START_SENT]) begin
               r.command  = CMD_SEND_BYTE;
               r.bus_byte = {seq_address, 1'b0};
               seq_phase  = PH_ADDR_W;
            end else if (seq_phase == PH_ADDR_W && ev.status_flags[SF_ADDR_ACKED]) begin
               r.command  = CMD_SEND_BYTE;
               r.bus_byte = seq_register;
               seq_phase  = PH_REG_SENT;
            end else if (seq_phase == PH_REG_SENT && ev.status_flags[SF_BYTE_DONE]) begin
               if (seq_read) begin
                  r.command = CMD_START;
                  seq_phase = PH_START_R;
               end else begin
                  r.command    = CMD_TX_DMA;
                  r.dma_length = seq_length;
                  seq_phase    = PH_TX_DMA;
               end
            end else if (seq_phase == PH_START_R && ev.status_flags[SF_START_SENT]) begin
               r.command  = CMD_SEND_BYTE;
               r.bus_byte = {seq_address, 1'b1};
               seq_phase  = PH_ADDR_R;
            end else if (seq_phase == PH_ADDR_R && ev.status_flags[SF_ADDR_ACKED]) begin
               if (seq_length == 16'd1) begin
                  r.command = CMD_NACK_STOP;
                  seq_phase = PH_RX_ONE;
               end else begin
                  r.command    = CMD_RX_DMA;
                  r.dma_length = seq_length;
                  seq_phase    = PH_RX_DMA;
               end
            end else if (seq_phase == PH_RX_ONE && ev.status_flags[SF_RX_READY]) begin
               r.read_byte  = ev.received_byte;
               r.read_valid = 1'b1;
               close_transaction(r, CMD_NONE, DONE_SUCCESS);
            end else if (seq_phase == PH_TX_WAIT_BTF && ev.status_flags[SF_BYTE_DONE]) begin
               close_transaction(r, CMD_STOP, DONE_SUCCESS);
            end
         end
         FUNC_BUS_ERROR: begin
            if (active && ev.error_flags != '0) close_transaction(r, CMD_STOP_RESET, DONE_ERROR);
         end
         FUNC_TX_DMA: begin
            if (active && ev.dma_fault) close_transaction(r, CMD_STOP_RESET, DONE_ERROR);
            else if (seq_phase == PH_TX_DMA && ev.dma_complete) seq_phase = PH_TX_WAIT_BTF;
         end
         FUNC_RX_DMA: begin
            if (active && ev.dma_fault) close_transaction(r, CMD_STOP_RESET, DONE_ERROR);
            else if (seq_phase == PH_RX_DMA && ev.dma_complete)
               close_transaction(r, CMD_STOP, DONE_SUCCESS);
         end
         FUNC_TICK: begin
            if (active) begin
               if (seq_ticks < TICKS_MAX) seq_ticks = seq_ticks + 16'd1;
               if (seq_ticks > timeout_limit) close_transaction(r, CMD_STOP_RESET, DONE_TIMEOUT);
            end
         end
         default: begin
         end
      endcase
      r.transaction_busy = (seq_phase != PH_IDLE);
      return r;
   endfunction

   function automatic req_type rand_event();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type make_begin(logic [6:0] dev, logic [7:0] regi, logic [15:0] len,
                                          logic rd, logic busy);
      req_type ev;
      ev = rand_event();
      ev.func             = FUNC_BEGIN;
      ev.device_address   = dev;
      ev.register_address = regi;
      ev.transfer_length  = len;
      ev.read_not_write   = rd;
      ev.bus_busy         = busy;
      return ev;
   endfunction

   function automatic req_type make_event(logic [2:0] f, logic [3:0] flags);
      req_type ev;
      ev = rand_event();
      ev.func = f;
      case (f) inside
         FUNC_STATUS:              ev.status_flags = flags;
         FUNC_BUS_ERROR:           ev.error_flags = flags;
         FUNC_TX_DMA, FUNC_RX_DMA: {ev.dma_fault, ev.dma_complete} = flags[1:0];
         default: begin
         end
      endcase
      return ev;
   endfunction

   // mostly the event the current phase waits for, the rest noise and aborts
   function automatic req_type pick_next_event();
      req_type     ev;
      int unsigned roll;
      ev = rand_event();
      roll = $urandom_range(99);
      if (roll < 12) return ev;
      if (roll < 22) begin
         ev.func = FUNC_TICK;
         return ev;
      end
      if (roll < 25) begin
         ev.func = FUNC_BUS_ERROR;
         return ev;
      end
      if (roll < 27) begin
         ev.func = roll[0] ? FUNC_TX_DMA : FUNC_RX_DMA;
         ev.dma_fault = 1'b1;
         return ev;
      end
      case (seq_phase) inside
         PH_START_W, PH_START_R: begin
            ev.func = FUNC_STATUS;
            ev.status_flags[SF_START_SENT] = 1'b1;
         end
         PH_ADDR_W, PH_ADDR_R: begin
            ev.func = FUNC_STATUS;
            ev.status_flags[SF_ADDR_ACKED] = 1'b1;
         end
         PH_REG_SENT, PH_TX_WAIT_BTF: begin
            ev.func = FUNC_STATUS;
            ev.status_flags[SF_BYTE_DONE] = 1'b1;
         end
         PH_RX_ONE: begin
            ev.func = FUNC_STATUS;
            ev.status_flags[SF_RX_READY] = 1'b1;
         end
         PH_TX_DMA: begin
            ev.func = FUNC_TX_DMA;
            ev.dma_fault = 1'b0;
            ev.dma_complete = 1'b1;
         end
         PH_RX_DMA: begin
            ev.func = FUNC_RX_DMA;
            ev.dma_fault = 1'b0;
            ev.dma_complete = 1'b1;
         end
         default: begin
            ev.func = FUNC_BEGIN;
            ev.bus_busy = ($urandom_range(9) == 0);
            if ($urandom_range(9) != 0) ev.transfer_length = 16'($urandom_range(34, 1));
         end
      endcase
      return ev;
   endfunction

   task automatic report_error(string msg);
      if (errors < 50) $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_error($sformatf("%s got %0h, want %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_stall <= gaps_on && ($urandom_range(99) < 36);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_error("result item with nothing expected");
         end else begin
            want = expected_rsp.pop_front();
            results_checked++;
            check_field("command", 16'(rsp_data.command), 16'(want.command));
            check_field("bus_byte", 16'(rsp_data.bus_byte), 16'(want.bus_byte));
            check_field("dma_length", rsp_data.dma_length, want.dma_length);
            check_field("begin_status", 16'(rsp_data.begin_status), 16'(want.begin_status));
            check_field("done_res", 16'(rsp_data.done_res), 16'(want.done_res));
            check_field("done_status", 16'(rsp_data.done_status), 16'(want.done_status));
            check_field("read_byte", 16'(rsp_data.read_byte), 16'(want.read_byte));
            check_field("read_valid", 16'(rsp_data.read_valid), 16'(want.read_valid));
            check_field("transaction_busy", 16'(rsp_data.transaction_busy),
                        16'(want.transaction_busy));
         end
      end
   end

   task automatic send_event(req_type ev);
      if (gaps_on && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(step_sequencer(ev));
      events_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_registers(logic [15:0] ticks, logic [15:0] max_len);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_data  <= ticks;
      do @(posedge clock); while (!csr_ready);
      timeout_limit = ticks;
      csr_index <= CSR_WRITE_MAX_LENGTH;
      csr_data  <= max_len;
      do @(posedge clock); while (!csr_ready);
      write_limit = max_len[5:0];
      csr_valid <= 1'b0;
      settings_used++;
      @(posedge clock);
   endtask

   task automatic test_begin_checks();
      send_event(make_begin(7'h00, 8'h00, 16'd0, 1'b1, 1'b0));
      send_event(make_begin(7'h7F, 8'hFF, 16'd33, 1'b0, 1'b0));
      send_event(make_begin(7'h7F, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
      send_event(make_begin(7'h7F, 8'hFF, 16'd32, 1'b0, 1'b0));
      send_event(make_begin(7'h00, 8'h00, 16'hFFFF, 1'b1, 1'b0));
      send_event(make_begin(7'h00, 8'h00, 16'd0, 1'b0, 1'b0));
      send_event(make_event(FUNC_BUS_ERROR, 4'h0));
      send_event(make_event(FUNC_BUS_ERROR, 4'h8));
   endtask

   task automatic test_write_sequence();
      send_event(make_begin(7'h7F, 8'hFF, 16'd1, 1'b0, 1'b0));
      send_event(make_event(FUNC_STATUS, ~ST_START));
      send_event(make_event(FUNC_TX_DMA, DMA_DONE));
      send_event(make_event(FUNC_STATUS, ST_START));
      send_event(make_event(FUNC_STATUS, ST_ACKED));
      send_event(make_event(FUNC_STATUS, ST_BYTE_DONE));
      send_event(make_event(FUNC_RX_DMA, DMA_DONE));
      send_event(make_event(FUNC_STATUS, ST_BYTE_DONE));
      send_event(make_event(FUNC_TX_DMA, 4'h0));
      send_event(make_event(FUNC_TX_DMA, DMA_DONE));
      send_event(make_event(FUNC_STATUS, ~ST_BYTE_DONE));
      send_event(make_event(FUNC_STATUS, ST_BYTE_DONE));
   endtask

   task automatic test_read_sequence();
      send_event(make_begin(7'h00, 8'h00, 16'd1, 1'b1, 1'b0));
      send_event(make_event(FUNC_STATUS, ST_START));
      send_event(make_event(FUNC_STATUS, ST_ACKED));
      send_event(make_event(FUNC_STATUS, ST_BYTE_DONE));
      send_event(make_event(FUNC_STATUS, ST_START));
      send_event(make_event(FUNC_STATUS, ST_ACKED));
      send_event(make_event(FUNC_STATUS, ST_RX_READY));
      send_event(make_begin(7'h55, 8'hAA, 16'hFFFF, 1'b1, 1'b0));
      send_event(make_event(FUNC_STATUS, ST_START));
      send_event(make_event(FUNC_STATUS, ST_ACKED));
      send_event(make_event(FUNC_STATUS, ST_BYTE_DONE));
      send_event(make_event(FUNC_STATUS, ST_START));
      send_event(make_event(FUNC_STATUS, ST_ACKED));
      send_event(make_event(FUNC_TX_DMA, DMA_DONE));
      send_event(make_event(FUNC_RX_DMA, DMA_DONE));
   endtask

   task automatic test_faults();
      send_event(make_event(FUNC_TICK, 4'h0));
      send_event(make_event(FUNC_BUS_ERROR, 4'hF));
      send_event(make_event(FUNC_TX_DMA, DMA_FAULT));
      send_event(make_event(FUNC_RX_DMA, DMA_FAULT | DMA_DONE));
      send_event(make_event(FUNC_SPARE_LO, 4'hF));
      send_event(make_event(FUNC_SPARE_HI, 4'hF));
      send_event(make_begin(7'h2A, 8'h5A, 16'd2, 1'b1, 1'b0));
      send_event(make_event(FUNC_RX_DMA, DMA_FAULT | DMA_DONE));
      send_event(make_begin(7'h15, 8'hA5, 16'd3, 1'b0, 1'b0));
      send_event(make_event(FUNC_TX_DMA, DMA_FAULT));
   endtask

   task automatic test_timeout_limits();
      set_registers(16'd0, 16'd32);
      send_event(make_begin(7'h01, 8'h01, 16'd4, 1'b0, 1'b0));
      send_event(make_event(FUNC_TICK, 4'h0));
      set_registers(16'd1, 16'd0);
      send_event(make_begin(7'h01, 8'h01, 16'd1, 1'b0, 1'b0));
      send_event(make_begin(7'h01, 8'h01, 16'd1, 1'b1, 1'b0));
      send_event(make_event(FUNC_TICK, 4'h0));
      send_event(make_event(FUNC_TICK, 4'h0));
      // run a burst of ticks under the widest timeout: it must not fire
      set_registers(16'hFFFF, 16'd63);
      send_event(make_begin(7'h01, 8'h01, 16'd33, 1'b0, 1'b0));
      send_event(make_begin(7'h01, 8'h01, 16'd32, 1'b0, 1'b0));
      gaps_on = 1'b0;
      repeat (40) send_event(make_event(FUNC_TICK, 4'h0));
      gaps_on = 1'b1;
      send_event(make_event(FUNC_BUS_ERROR, 4'h1));
   endtask

   task automatic test_random_traffic();
      set_registers(TIMEOUT_TICKS_RESET, 16'(WRITE_MAX_LENGTH_RESET));
      repeat (120) send_event(pick_next_event());
      wait_idle();
      repeat (120) send_event(pick_next_event());
      set_registers(16'd1, 16'd1);
      repeat (150) send_event(pick_next_event());
      set_registers(16'hFFFF, 16'd63);
      gaps_on = 1'b0;
      repeat (200) send_event(pick_next_event());
      gaps_on = 1'b1;
      set_registers(16'($urandom), 16'($urandom));
      repeat (200) send_event(pick_next_event());
      set_registers(16'd0, 16'd0);
      repeat (80) send_event(pick_next_event());
      set_registers(16'($urandom_range(40, 2)), 16'($urandom_range(32, 1)));
      repeat (150) send_event(pick_next_event());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_begin_checks();
      test_write_sequence();
      test_read_sequence();
      test_faults();
      test_timeout_limits();
      test_random_traffic();
      wait_idle();
      $display("Covered begin checks, write and read sequences, aborts, timeouts, widest timeout");
      $display("%0d events sent, %0d results checked, %0d register settings",
               events_sent, results_checked, settings_used);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
src/i2c_rts_pkg.sv
src/i2c_register_transaction_sequencer.sv
verif/i2c_register_transaction_sequencer_test.sv
